// ===== design/bds_pkg.sv =====
// Shared constants and types for the 2x2 box downsampler.
`default_nettype none
package bds_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WCFG_W     = COL_W + 1;
    localparam int HCFG_W     = ROW_W + 1;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int SLOT_W     = $clog2(LINE_DEPTH);

    localparam int PIX_W      = 8;
    localparam int PAIR_W     = PIX_W + 1;
    localparam int SUM_W      = PIX_W + 2;

    localparam int CFG_DATA_W = HCFG_W;

    localparam logic [WCFG_W-1:0] WIDTH_RESET  = WCFG_W'(1024);
    localparam logic [HCFG_W-1:0] HEIGHT_RESET = HCFG_W'(768);

    localparam int OBUF_DEPTH = 3;
    localparam int OBUF_PTR_W = 2;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] avg_pixel;
        logic             frame_done;
    } result_t;

endpackage
`default_nettype wire

// ===== design/bds_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
`default_nettype none
module bds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== design/box_downsample_2x2.sv =====
// 2x2 box-filter downsampler for an 8-bit grayscale pixel stream.
`default_nettype none
// Pixels enter in raster order, one per request, for a frame of image_width by
// image_height (0 reads as 1, values above 1024 or 4096 clamp to the maximum,
// but the width keeps only the low 11 bits of cfg_data). Each result is the
// rounded average (sum+2)>>2 of one 2x2 block, produced by the pixel at an odd
// column of an odd row; an odd last column or row yields nothing. m_tlast marks
// the final result of the half-size frame. The block takes one pixel per clock
// while s_tready is high: each pixel makes at most one access to the 512-entry
// pair-sum line memory, a write on even rows and a read on odd rows. A result
// enters the output buffer at the clock edge after the one that accepts its
// pixel. A three-entry output buffer absorbs output stalls; s_tready depends
// only on registered state. The line memory needs no clearing pass after reset.
// Write configuration only while no request is in flight.
module box_downsample_2x2 (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // slave pixel stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,   // [7:0] pixel
    // master result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [7:0]                       m_tdata,   // [7:0] avg_pixel
    output logic                                  m_tlast,   // frame_done
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire bds_pkg::cfg_index_t              cfg_index,
    input  wire logic [bds_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bds_pkg::*;

    // configuration
    logic [WCFG_W-1:0] width_reg;
    logic [HCFG_W-1:0] height_reg;
    logic [WCFG_W-1:0] w_eff;
    logic [HCFG_W-1:0] h_eff;

    // position and pixel hold
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [PIX_W-1:0]  left_reg, left_next;

    // stage after the memory read
    logic              p1_valid_reg;
    logic [PAIR_W-1:0] p1_pair_reg;
    logic              p1_last_reg;

    // output buffer
    result_t                 obuf_reg [OBUF_DEPTH];
    logic [OBUF_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg, count_reg;

    logic              s_accept, m_accept;
    logic [COL_W-1:0]  col_cur;
    logic [ROW_W-1:0]  row_cur;
    logic [WCFG_W-1:0] col_inc;
    logic [HCFG_W-1:0] row_inc;
    logic [PAIR_W-1:0] pair;
    logic              is_last;
    logic              ram_we, ram_re;
    logic [SLOT_W-1:0] slot;
    logic [PAIR_W-1:0] ram_rdata;
    logic [SUM_W-1:0]  block_sum;
    result_t           p1_result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[WCFG_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (width_reg == '0) begin
            w_eff = WCFG_W'(1);
        end else if (width_reg > WCFG_W'(MAX_WIDTH)) begin
            w_eff = WCFG_W'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        priority if (height_reg == '0) begin
            h_eff = HCFG_W'(1);
        end else if (height_reg > HCFG_W'(MAX_HEIGHT)) begin
            h_eff = HCFG_W'(MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
    end

    // accept when the buffer can hold everything already in flight plus one
    assign s_tready = (WCFG_W'(count_reg) + WCFG_W'(p1_valid_reg)) <= WCFG_W'(OBUF_DEPTH - 1);
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;

    always_comb begin
        // wrap positions left beyond a reduced limit
        col_cur = ({1'b0, col_reg} >= w_eff) ? '0 : col_reg;
        row_cur = ({1'b0, row_reg} >= h_eff) ? '0 : row_reg;
        col_inc = {1'b0, col_cur} + WCFG_W'(1);
        row_inc = {1'b0, row_cur} + HCFG_W'(1);
        pair    = {1'b0, left_reg} + {1'b0, s_tdata};
        slot    = col_cur[COL_W-1:1];
        is_last = ({1'b0, col_cur} == ((w_eff & ~WCFG_W'(1)) - WCFG_W'(1)))
               && ({1'b0, row_cur} == ((h_eff & ~HCFG_W'(1)) - HCFG_W'(1)));

        ram_we    = s_accept && col_cur[0] && !row_cur[0];
        ram_re    = s_accept && col_cur[0] && row_cur[0];
        left_next = (s_accept && !col_cur[0]) ? s_tdata : left_reg;

        col_next = col_reg;
        row_next = row_reg;
        if (s_accept) begin
            if (col_inc >= w_eff) begin
                col_next = '0;
                row_next = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                col_next = col_inc[COL_W-1:0];
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            left_reg <= left_next;
        end
    end

    bds_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (pair),
        .re    (ram_re),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= ram_re;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_re) begin
            p1_pair_reg <= pair;
            p1_last_reg <= is_last;
        end
    end

    always_comb begin
        block_sum            = {1'b0, ram_rdata} + {1'b0, p1_pair_reg} + SUM_W'(2);
        p1_result.avg_pixel  = block_sum[SUM_W-1:2];
        p1_result.frame_done = p1_last_reg;
    end

    // output buffer: push from the read stage, pop on the master request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (p1_valid_reg) begin
                wr_ptr_reg <= (wr_ptr_reg == OBUF_PTR_W'(OBUF_DEPTH - 1)) ? '0
                            : wr_ptr_reg + OBUF_PTR_W'(1);
            end
            if (m_accept) begin
                rd_ptr_reg <= (rd_ptr_reg == OBUF_PTR_W'(OBUF_DEPTH - 1)) ? '0
                            : rd_ptr_reg + OBUF_PTR_W'(1);
            end
            count_reg <= count_reg + OBUF_PTR_W'(p1_valid_reg) - OBUF_PTR_W'(m_accept);
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_valid_reg) begin
            obuf_reg[wr_ptr_reg] <= p1_result;
        end
    end

    assign m_tvalid = count_reg != '0;
    assign m_tdata  = obuf_reg[rd_ptr_reg].avg_pixel;
    assign m_tlast  = obuf_reg[rd_ptr_reg].frame_done;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg |-> count_reg <= OBUF_PTR_W'(OBUF_DEPTH - 1))
        else $error("output buffer overflow");

    a_read_source: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg |-> $past(ram_re))
        else $error("result stage without a line read");

    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("line memory read and write in one cycle");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= OBUF_PTR_W'(OBUF_DEPTH))
        else $error("output buffer count out of range");
`endif

endmodule
`default_nettype wire
